/* hdl/nearest_landmark_association_top_defines.svh */
// assertion macros used by the checker
`ifndef NEAREST_LANDMARK_ASSOCIATION_TOP_DEFINES_SVH
`define NEAREST_LANDMARK_ASSOCIATION_TOP_DEFINES_SVH

// plain property, sampled on the rising clock, off during reset
`define NLA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// consequence checked in the cycle after its antecedent
`define NLA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/nla_pkg.sv */
package nla_pkg;

  localparam int CoordW      = 20;
  localparam int IdW         = 16;
  localparam int OpW         = 2;
  localparam int StatusW     = 2;
  localparam int MaxEntries  = 64;
  // distance pipe: abs diff, squares, sum, best update
  localparam int DistLatency = 4;
  localparam int MagW        = CoordW;
  localparam int SqW         = 2 * MagW;
  localparam int DistW       = SqW + 1;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_ASSOC  = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_ROTATE
  } cell_mode_e;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } fsm_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic        [IdW-1:0]    id;
  } entry_t;

  typedef struct packed {
    logic start;
    logic feed;
  } dist_ctrl_t;

endpackage

/* hdl/nla_in_if.sv */
interface nla_in_if;
  logic                             valid;
  logic                             ready;
  logic [nla_pkg::OpW-1:0]          op;
  logic signed [nla_pkg::CoordW-1:0] pos_x;
  logic signed [nla_pkg::CoordW-1:0] pos_y;
  logic [nla_pkg::IdW-1:0]          landmark_id;

  modport source (output valid, op, pos_x, pos_y, landmark_id, input ready);
  modport sink   (input valid, op, pos_x, pos_y, landmark_id, output ready);
endinterface

/* hdl/nla_out_if.sv */
interface nla_out_if;
  logic                         valid;
  logic                         ready;
  logic [nla_pkg::IdW-1:0]      match_id;
  logic [nla_pkg::StatusW-1:0]  status;

  modport source (output valid, match_id, status, input ready);
  modport sink   (input valid, match_id, status, output ready);
endinterface

/* hdl/nla_cell.sv */
module nla_cell (
  input  logic                clk_i,
  input  nla_pkg::cell_mode_e mode_i,
  input  nla_pkg::entry_t     prev_i,
  input  nla_pkg::entry_t     next_i,
  output nla_pkg::entry_t     entry_o
);

  nla_pkg::entry_t entry_q, entry_d;

  always_comb begin
    case (mode_i)
      nla_pkg::CELL_SHIFT:  entry_d = prev_i;
      nla_pkg::CELL_ROTATE: entry_d = next_i;
      default:              entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

/* hdl/nla_dist.sv */
module nla_dist (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  nla_pkg::dist_ctrl_t               ctrl_i,
  input  nla_pkg::entry_t                   entry_i,
  input  logic signed [nla_pkg::CoordW-1:0] obs_x_i,
  input  logic signed [nla_pkg::CoordW-1:0] obs_y_i,
  output logic [nla_pkg::IdW-1:0]           best_id_o
);

  localparam int CW = nla_pkg::CoordW;
  localparam int MW = nla_pkg::MagW;
  localparam int SW = nla_pkg::SqW;
  localparam int DW = nla_pkg::DistW;

  logic signed [CW:0] dx, dy;
  logic [MW-1:0] ax_d, ay_d;

  logic [MW-1:0] ax_q, ay_q;
  logic [SW-1:0] sx_q, sy_q;
  logic [DW-1:0] sum_q, best_q;
  logic [nla_pkg::IdW-1:0] id_a_q, id_b_q, id_c_q, best_id_q;
  logic vld_a_q, vld_b_q, vld_c_q, found_q;

  always_comb begin
    dx = {entry_i.x[CW-1], entry_i.x} - {obs_x_i[CW-1], obs_x_i};
    dy = {entry_i.y[CW-1], entry_i.y} - {obs_y_i[CW-1], obs_y_i};
    ax_d = dx[CW] ? MW'(-dx) : dx[MW-1:0];
    ay_d = dy[CW] ? MW'(-dy) : dy[MW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      vld_a_q <= ctrl_i.feed;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      if (ctrl_i.start) begin
        found_q <= 1'b0;
      end else if (vld_c_q) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    id_a_q <= entry_i.id;
    sx_q   <= SW'(ax_q) * SW'(ax_q);
    sy_q   <= SW'(ay_q) * SW'(ay_q);
    id_b_q <= id_a_q;
    sum_q  <= {1'b0, sx_q} + {1'b0, sy_q};
    id_c_q <= id_b_q;
    // newest entry comes first, so ties go to the later (older) one
    if (vld_c_q && (!found_q || sum_q <= best_q)) begin
      best_q    <= sum_q;
      best_id_q <= id_c_q;
    end
  end

  assign best_id_o = best_id_q;

endmodule

/* hdl/nearest_landmark_association_top.sv */
// Nearest landmark association. Landmarks are appended into a ring of
// MAX_ENTRIES cells, newest at the head. Clear and append give their word
// one cycle after acceptance. An associate on a loaded table rotates the
// ring once around, one entry per cycle past a four-stage squared-distance
// pipe, so the scan passes every cell of the ring and lasts equally long
// whatever the fill level; on an empty table it answers at once. A new word
// is taken when no scan is running and the output register is free or
// being read in the same cycle. Ties go to the earliest appended entry.
module nearest_landmark_association_top #(
  parameter int MAX_ENTRIES = nla_pkg::MaxEntries
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  nla_in_if.sink         in_i,
  nla_out_if.source      out_o
);

  localparam int CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int ScanW = $clog2(MAX_ENTRIES + nla_pkg::DistLatency);
  localparam logic [ScanW-1:0] ScanLast =
    ScanW'(MAX_ENTRIES + nla_pkg::DistLatency - 1);

  nla_pkg::fsm_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [ScanW-1:0] scan_q, scan_d;
  logic signed [nla_pkg::CoordW-1:0] obs_x_q, obs_y_q;

  logic out_vld_q;
  logic [nla_pkg::IdW-1:0]     out_id_q;
  logic [nla_pkg::StatusW-1:0] out_status_q;

  logic in_rdy, in_acc, scan_last, load_out, start_scan, table_full;
  logic [nla_pkg::IdW-1:0]     res_id;
  nla_pkg::status_e            res_status;
  nla_pkg::cell_mode_e         mode;
  nla_pkg::dist_ctrl_t         dctrl;
  nla_pkg::entry_t             new_entry;
  nla_pkg::entry_t             cells [MAX_ENTRIES];
  logic [nla_pkg::IdW-1:0]     best_id;

  assign table_full = (count_q == CntW'(MAX_ENTRIES));
  assign scan_last  = (state_q == nla_pkg::S_SCAN) && (scan_q == ScanLast);
  assign in_acc     = in_i.valid && in_rdy;
  assign new_entry  = '{x: in_i.pos_x, y: in_i.pos_y, id: in_i.landmark_id};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nla_pkg::S_IDLE: begin
        if (start_scan) state_d = nla_pkg::S_SCAN;
      end
      nla_pkg::S_SCAN: begin
        if (scan_last) state_d = nla_pkg::S_IDLE;
      end
      default: state_d = nla_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_rdy     = 1'b0;
    start_scan = 1'b0;
    load_out   = 1'b0;
    res_id     = '0;
    res_status = nla_pkg::STATUS_OK;
    mode       = nla_pkg::CELL_HOLD;
    count_d    = count_q;
    scan_d     = scan_q;
    dctrl      = '0;
    case (state_q)
      nla_pkg::S_IDLE: begin
        in_rdy = !out_vld_q || out_o.ready;
        scan_d = '0;
        if (in_acc) begin
          case (nla_pkg::op_e'(in_i.op))
            nla_pkg::OP_CLEAR: begin
              load_out = 1'b1;
              count_d  = '0;
            end
            nla_pkg::OP_APPEND: begin
              load_out = 1'b1;
              if (table_full) begin
                res_status = nla_pkg::STATUS_FULL;
              end else begin
                mode    = nla_pkg::CELL_SHIFT;
                count_d = count_q + 1'b1;
              end
            end
            nla_pkg::OP_ASSOC: begin
              if (count_q == '0) begin
                load_out   = 1'b1;
                res_status = nla_pkg::STATUS_EMPTY;
              end else begin
                start_scan  = 1'b1;
                dctrl.start = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      nla_pkg::S_SCAN: begin
        scan_d     = scan_q + 1'b1;
        dctrl.feed = (scan_q < ScanW'(count_q));
        if (scan_q < ScanW'(MAX_ENTRIES)) mode = nla_pkg::CELL_ROTATE;
        if (scan_last) begin
          load_out = 1'b1;
          res_id   = best_id;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nla_pkg::S_IDLE;
      count_q   <= '0;
      scan_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_id_q     <= res_id;
      out_status_q <= res_status;
    end
    if (start_scan) begin
      obs_x_q <= in_i.pos_x;
      obs_y_q <= in_i.pos_y;
    end
  end

  // ring of table cells: append shifts toward the tail, scan rotates to the head
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    nla_cell u_cell (
      .clk_i   (clk_i),
      .mode_i  (mode),
      .prev_i  ((i == 0) ? new_entry : cells[(i == 0) ? 0 : i - 1]),
      .next_i  (cells[(i + 1) % MAX_ENTRIES]),
      .entry_o (cells[i])
    );
  end

  nla_dist u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (dctrl),
    .entry_i   (cells[0]),
    .obs_x_i   (obs_x_q),
    .obs_y_i   (obs_y_q),
    .best_id_o (best_id)
  );

  assign in_i.ready     = in_rdy;
  assign out_o.valid    = out_vld_q;
  assign out_o.match_id = out_id_q;
  assign out_o.status   = out_status_q;

endmodule

/* hdl/nla_checker.sv */
`include "nearest_landmark_association_top_defines.svh"

module nla_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [nla_pkg::OpW-1:0]     in_op_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [nla_pkg::IdW-1:0]     out_match_id_i,
  input logic [nla_pkg::StatusW-1:0] out_status_i
);

  // a word waiting at the output stays until taken
  `NLA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "output word dropped while stalled")

  // only a successful association carries an id
  `NLA_ASSERT(a_id_zero, clk_i, rst_ni, !out_valid_i || out_status_i == nla_pkg::STATUS_OK || out_match_id_i == '0, "non-ok word with nonzero id")

  // an association either answers at once or occupies the block
  `NLA_ASSERT_NEXT(a_scan_busy, clk_i, rst_ni, in_valid_i && in_ready_i && in_op_i == nla_pkg::OP_ASSOC, out_valid_i || !in_ready_i, "association neither answered nor started a scan")

  // no output word appears without a prior accepted input
  `NLA_ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !out_valid_i && in_ready_i && !in_valid_i, !out_valid_i, "unexpected output word")

endmodule

bind nearest_landmark_association_top nla_checker u_nla_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_op_i        (in_i.op),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_match_id_i (out_o.match_id),
  .out_status_i   (out_o.status)
);

/* test/nla_checker.sv */
module nla_tb_checker (
  input  logic clk_i,
  input  logic rst_ni,
  nla_in_if    in_w,
  nla_out_if   out_w,
  output int   fail_count_o,
  output int   answer_count_o,
  output int   drop_count_o,
  output int   pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CoordW     = nla_pkg::CoordW;
  localparam int IdW        = nla_pkg::IdW;
  localparam int OpW        = nla_pkg::OpW;
  localparam int DistW      = nla_pkg::DistW;
  localparam int MaxEntries = nla_pkg::MaxEntries;

  typedef struct {
    logic [IdW-1:0]   match_id;
    nla_pkg::status_e status;
  } answer_t;

  answer_t                  awaited_answers[$];
  logic signed [CoordW-1:0] lm_x  [MaxEntries];
  logic signed [CoordW-1:0] lm_y  [MaxEntries];
  logic [IdW-1:0]           lm_id [MaxEntries];
  int unsigned              lm_count;
  int                       fails;
  int                       answers;
  int                       drops;

  function automatic logic [DistW-1:0] range_sq(
    logic signed [CoordW-1:0] ax, logic signed [CoordW-1:0] ay,
    logic signed [CoordW-1:0] bx, logic signed [CoordW-1:0] by);
    longint dx;
    longint dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return DistW'(dx * dx + dy * dy);
  endfunction

  // applies one word to the landmark table, returns 1 when it draws an answer
  function automatic bit apply_word(
    logic [OpW-1:0] op, logic signed [CoordW-1:0] px, logic signed [CoordW-1:0] py,
    logic [IdW-1:0] lid, output answer_t ans);
    logic [DistW-1:0] best;
    logic [DistW-1:0] d;
    ans.match_id = '0;
    ans.status   = nla_pkg::STATUS_OK;
    case (op)
      nla_pkg::OP_CLEAR: lm_count = 0;
      nla_pkg::OP_APPEND: begin
        if (lm_count < MaxEntries) begin
          lm_x[lm_count]  = px;
          lm_y[lm_count]  = py;
          lm_id[lm_count] = lid;
          lm_count++;
        end else begin
          ans.status = nla_pkg::STATUS_FULL;
        end
      end
      nla_pkg::OP_ASSOC: begin
        if (lm_count == 0) begin
          ans.status = nla_pkg::STATUS_EMPTY;
        end else begin
          best         = range_sq(lm_x[0], lm_y[0], px, py);
          ans.match_id = lm_id[0];
          // strict compare keeps the earliest entry on a tie
          for (int k = 1; k < lm_count; k++) begin
            d = range_sq(lm_x[k], lm_y[k], px, py);
            if (d < best) begin
              best         = d;
              ans.match_id = lm_id[k];
            end
          end
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      lm_count = 0;
      awaited_answers.delete();
      fails   = 0;
      answers = 0;
      drops   = 0;
    end else begin
      // the answer to a word never leaves on the edge that takes the word
      if (out_w.valid && out_w.ready) begin
        if (awaited_answers.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected answer: match_id %h status %0d", out_w.match_id,
                     out_w.status);
        end else begin
          want = awaited_answers.pop_front();
          answers++;
          if (out_w.match_id !== want.match_id || out_w.status !== want.status) begin
            fails++;
            if (fails <= 10)
              $display("answer mismatch: match_id exp %h got %h, status exp %0d got %0d",
                       want.match_id, out_w.match_id, want.status, out_w.status);
          end
        end
      end
      if (in_w.valid && in_w.ready) begin
        if (apply_word(in_w.op, in_w.pos_x, in_w.pos_y, in_w.landmark_id, want)) begin
          awaited_answers.insert(awaited_answers.size(), want);
          if (want.status == nla_pkg::STATUS_FULL) drops++;
        end
      end
    end
    fail_count_o    <= fails;
    answer_count_o  <= answers;
    drop_count_o    <= drops;
    pending_count_o <= awaited_answers.size();
  end

endmodule

/* test/tb_nearest_landmark_association_top.sv */
module tb_nearest_landmark_association_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CoordW = nla_pkg::CoordW;
  localparam int IdW    = nla_pkg::IdW;
  localparam int OpW    = nla_pkg::OpW;

  localparam logic [OpW-1:0]           OP_UNUSED  = 2'd3;
  localparam logic signed [CoordW-1:0] CoordMax   = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin   = {1'b1, {(CoordW-1){1'b0}}};
  localparam int unsigned              TotalWords = 1270;
  localparam int unsigned              CycleLimit = 600_000;

  logic clk_i = 1'b0;
  logic rst_ni;

  nla_in_if  in_if ();
  nla_out_if out_if ();

  int          mismatches;
  int          answers_seen;
  int          drops_seen;
  int          answers_waiting;
  bit          calm;
  int unsigned cycle_count = 0;
  int unsigned stall_left;
  int unsigned useful_words;
  int unsigned op_tally [4];

  logic signed [CoordW-1:0] placed_x [$];
  logic signed [CoordW-1:0] placed_y [$];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  nearest_landmark_association_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  nla_tb_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_w            (in_if),
    .out_w           (out_if),
    .fail_count_o    (mismatches),
    .answer_count_o  (answers_seen),
    .drop_count_o    (drops_seen),
    .pending_count_o (answers_waiting)
  );

  // receiver stalls in bursts of random length
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 11);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d answers outstanding", cycle_count,
               answers_waiting);
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic signed [CoordW-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return CoordMax;
      1:       return CoordMin;
      2:       return '0;
      default: return CoordW'($urandom);
    endcase
  endfunction

  function automatic logic signed [CoordW-1:0] near_coord(logic signed [CoordW-1:0] base);
    return CoordW'(int'(base) + int'($urandom_range(0, 32)) - 16);
  endfunction

  task automatic send_word(logic [OpW-1:0] op, logic signed [CoordW-1:0] px,
                           logic signed [CoordW-1:0] py, logic [IdW-1:0] lid);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.op          <= op;
    in_if.pos_x       <= px;
    in_if.pos_y       <= py;
    in_if.landmark_id <= lid;
    do @(posedge clk_i); while (!in_if.ready);
    op_tally[op]++;
    if (op != OP_UNUSED) useful_words++;
  endtask

  initial begin
    int                       n_app;
    int                       n_assoc;
    int                       k;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;

    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.op          <= nla_pkg::OP_CLEAR;
    in_if.pos_x       <= '0;
    in_if.pos_y       <= '0;
    in_if.landmark_id <= '0;
    calm              <= 1'b0;
    useful_words = 0;
    foreach (op_tally[i]) op_tally[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners: empty table, extremes, ties, unused op
    send_word(nla_pkg::OP_ASSOC, CoordMax, CoordMin, 16'hffff);
    send_word(nla_pkg::OP_CLEAR, CoordMin, CoordMax, 16'h0000);
    send_word(nla_pkg::OP_APPEND, CoordMax, CoordMax, 16'hffff);
    send_word(nla_pkg::OP_APPEND, CoordMin, CoordMin, 16'h0000);
    send_word(nla_pkg::OP_APPEND, '0, '0, 16'h1234);
    send_word(nla_pkg::OP_APPEND, '0, '0, 16'h4321);
    send_word(nla_pkg::OP_ASSOC, '0, '0, 16'h0000);
    send_word(nla_pkg::OP_ASSOC, CoordMax, CoordMax, 16'h0000);
    send_word(nla_pkg::OP_ASSOC, CoordMin, CoordMin, 16'hffff);
    send_word(nla_pkg::OP_ASSOC, CoordMax, CoordMin, 16'h0000);
    send_word(nla_pkg::OP_ASSOC, CoordMin, CoordMax, 16'h0000);
    send_word(OP_UNUSED, CoordMax, CoordMin, 16'hffff);
    send_word(nla_pkg::OP_CLEAR, '0, '0, 16'h0000);
    send_word(nla_pkg::OP_ASSOC, '0, '0, 16'h0000);
    send_word(nla_pkg::OP_APPEND, 20'sd10, '0, 16'h0007);
    send_word(nla_pkg::OP_APPEND, -20'sd10, '0, 16'h0008);
    send_word(nla_pkg::OP_ASSOC, '0, '0, 16'h0000);
    send_word(nla_pkg::OP_APPEND, '0, 20'sd10, 16'h0009);
    send_word(nla_pkg::OP_ASSOC, '0, 20'sd5, 16'h0000);
    send_word(OP_UNUSED, '0, '0, 16'h0000);
    send_word(nla_pkg::OP_ASSOC, 20'sd10, 20'sd10, 16'h0000);
    send_word(nla_pkg::OP_CLEAR, '0, '0, 16'hffff);

    while (useful_words < TotalWords) begin
      calm <= (useful_words > TotalWords - 200);
      if ($urandom_range(0, 4) != 0) begin
        send_word(nla_pkg::OP_CLEAR, pick_coord(), pick_coord(), IdW'($urandom));
        placed_x.delete();
        placed_y.delete();
      end
      // now and then fill the table close to or past capacity
      n_app = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 72) : $urandom_range(0, 12);
      cx = pick_coord();
      cy = pick_coord();
      for (int i = 0; i < n_app; i++) begin
        case ($urandom_range(0, 3))
          0: begin
            px = pick_coord();
            py = pick_coord();
          end
          1: begin
            if (placed_x.size() != 0) begin
              k  = $urandom_range(0, placed_x.size() - 1);
              px = placed_x[k];
              py = placed_y[k];
            end else begin
              px = pick_coord();
              py = pick_coord();
            end
          end
          default: begin
            px = near_coord(cx);
            py = near_coord(cy);
          end
        endcase
        placed_x.insert(placed_x.size(), px);
        placed_y.insert(placed_y.size(), py);
        send_word(nla_pkg::OP_APPEND, px, py, IdW'($urandom));
        if ($urandom_range(0, 15) == 0)
          send_word(OP_UNUSED, pick_coord(), pick_coord(), IdW'($urandom));
      end
      n_assoc = $urandom_range(1, 6);
      for (int i = 0; i < n_assoc; i++) begin
        case ($urandom_range(0, 3))
          0: begin
            px = pick_coord();
            py = pick_coord();
          end
          1: begin
            if (placed_x.size() != 0) begin
              k  = $urandom_range(0, placed_x.size() - 1);
              px = placed_x[k];
              py = placed_y[k];
            end else begin
              px = pick_coord();
              py = pick_coord();
            end
          end
          default: begin
            px = near_coord(cx);
            py = near_coord(cy);
          end
        endcase
        send_word(nla_pkg::OP_ASSOC, px, py, IdW'($urandom));
      end
    end

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (answers_waiting != 0) @(posedge clk_i);
    repeat (2 * nla_pkg::MaxEntries) @(posedge clk_i);

    $display("covered %0d words: %0d clear, %0d append, %0d associate, %0d unused op",
             op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
             op_tally[nla_pkg::OP_CLEAR], op_tally[nla_pkg::OP_APPEND],
             op_tally[nla_pkg::OP_ASSOC], op_tally[OP_UNUSED]);
    $display("%0d answers checked, %0d appends dropped on a full table, %0d mismatches",
             answers_seen, drops_seen, mismatches);
    if (mismatches == 0 && answers_waiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
